[rtl/gqg_pkg.sv]
// ----------------------------------------------------------------------------
// gqg_pkg
// Shared types, constants and arithmetic helpers of the glyph quad generator.
// ----------------------------------------------------------------------------
package gqg_pkg;

    localparam int GLYPH_ENTRIES_DEF = 128;

    localparam logic [15:0] SCALE_RESET       = 16'd256;
    localparam logic [15:0] REPLACEMENT_RESET = 16'd63;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_PLACE = 2'd1,
        OP_PEN   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_SCALE_X     = 2'd0,
        REG_SCALE_Y     = 2'd1,
        REG_REPLACEMENT = 2'd2
    } reg_idx_t;

    // One stored glyph record (code kept in a store of its own).
    typedef struct packed {
        logic signed [15:0] off_x;
        logic signed [15:0] off_y;
        logic signed [15:0] w;
        logic signed [15:0] h;
        logic [15:0]        u;
        logic [15:0]        v;
        logic [15:0]        tw;
        logic [15:0]        th;
        logic signed [15:0] adv_x;
        logic signed [15:0] adv_y;
    } glyph_t;

    // Saturate a 26-bit signed value to the signed 24-bit range.
    function automatic logic signed [23:0] sat24(input logic signed [25:0] a);
        logic signed [23:0] r;
        if (a > 26'sd8388607)
            r = 24'sd8388607;
        else if (a < -26'sd8388608)
            r = -24'sd8388608;
        else
            r = a[23:0];
        return r;
    endfunction

    // Reduce a Q17.16 product to Q16.8 with round half up, then saturate.
    function automatic logic signed [23:0] reduce_q(input logic signed [32:0] p);
        logic signed [33:0] t;
        logic signed [25:0] s;
        t = {p[32], p} + 34'sd128;
        s = t[33:8];
        return sat24(s);
    endfunction

    // Unsigned 16-bit saturating add.
    function automatic logic [15:0] satu16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

endpackage

[rtl/gqg_if.sv]
// ----------------------------------------------------------------------------
// gqg_if
// Valid/ready channel interfaces for commands, vertices and register writes.
// ----------------------------------------------------------------------------
interface gqg_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [15:0]        char_code;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] glyph_w;
    logic signed [15:0] glyph_h;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [15:0]        tex_w;
    logic [15:0]        tex_h;
    logic signed [15:0] advance_x;
    logic signed [15:0] advance_y;

    modport source (output valid, op, char_code, offset_x, offset_y, glyph_w, glyph_h,
                    tex_u, tex_v, tex_w, tex_h, advance_x, advance_y, input ready);
    modport sink   (input valid, op, char_code, offset_x, offset_y, glyph_w, glyph_h,
                    tex_u, tex_v, tex_w, tex_h, advance_x, advance_y, output ready);
endinterface

interface gqg_vtx_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] vert_x;
    logic signed [23:0] vert_y;
    logic [15:0]        out_u;
    logic [15:0]        out_v;
    logic               last_vertex;

    modport source (output valid, vert_x, vert_y, out_u, out_v, last_vertex, input ready);
    modport sink   (input valid, vert_x, vert_y, out_u, out_v, last_vertex, output ready);
endinterface

interface gqg_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/gqg_table.sv]
// ----------------------------------------------------------------------------
// gqg_table
// Glyph table: one memory of codes and one of records, both read through
// a registered output.
// ----------------------------------------------------------------------------
module gqg_table
    import gqg_pkg::*;
#(
    parameter int ENTRIES = GLYPH_ENTRIES_DEF,
    parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_code,
    input  glyph_t        wr_glyph,
    input  logic [AW-1:0] code_addr,
    output logic [15:0]   code_q,
    input  logic [AW-1:0] rec_addr,
    output glyph_t        rec_q
);

    logic [15:0] code_mem [ENTRIES];
    glyph_t      rec_mem  [ENTRIES];

    // Code memory: written on load, read during the scan.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            code_mem[wr_addr] <= wr_code;
        end
        code_q <= code_mem[code_addr];
    end

    // Record memory: written on load, read at the address of the hit entry.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rec_mem[wr_addr] <= wr_glyph;
        end
        rec_q <= rec_mem[rec_addr];
    end

endmodule

[rtl/glyph_quad_generator_unit.sv]
// ----------------------------------------------------------------------------
// glyph_quad_generator_unit
// Bitmap font text quad generator with a scanned glyph table.
// ----------------------------------------------------------------------------
// Usage: commands arrive on cmd as words. A load word appends a glyph record
// (ignored once the table is full). A place word searches the table for the
// first matching code, then for the replacement code, then falls back to
// entry 0, and emits six vertex words v0,v2,v1,v0,v3,v2 on vtx unless the
// glyph has zero width and height; the pen then advances. A pen word zeroes
// the pen. Register writes on cfg set scale_x, scale_y, replacement_code.
// Throughput: one command at a time. A place word scans the code memory
// one entry per cycle, with two searches at most over the loaded entries,
// then reads the record, scales it, emits the six vertex words and closes.
// The single read port of the code memory sets the scan rate.
// Reset clears the entry count and the pen and returns the registers to
// their defaults; the table itself is not cleared. When vtx stalls, the
// vertex word holds and the unit waits.
// ----------------------------------------------------------------------------
module glyph_quad_generator_unit
    import gqg_pkg::*;
#(
    parameter int GLYPH_ENTRIES = GLYPH_ENTRIES_DEF
)
(
    input logic     clk,
    input logic     rst_n,
    gqg_cmd_if.sink   cmd,
    gqg_vtx_if.source vtx,
    gqg_cfg_if.sink   cfg
);

    localparam int AW = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
    localparam int CW = $clog2(GLYPH_ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(GLYPH_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SCAN_CHECK, S_REC_RD, S_REC_WAIT,
        S_MUL1, S_MUL2, S_SUM, S_EMIT, S_DONE
    } state_t;

    state_t             state_reg;
    logic [15:0]        scale_x_reg, scale_y_reg, repl_reg;
    logic [CW-1:0]      count_reg;
    logic signed [23:0] pen_x_reg, pen_y_reg;
    logic [15:0]        code_reg;
    logic [15:0]        key_reg;
    logic               second_reg;
    logic [CW-1:0]      scan_reg;
    logic [AW-1:0]      hit_reg;
    logic               rd_valid_reg;
    logic [CW-1:0]      rd_idx_reg;
    logic [2:0]         vcnt_reg;
    logic signed [32:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [23:0] sx_reg, sy_reg, sw_reg, sh_reg;
    logic signed [23:0] ax_reg, ay_reg;
    logic signed [23:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [15:0]        u0_reg, v0_reg, u1_reg, v1_reg;
    logic               vvalid_reg;
    logic signed [23:0] vx_reg, vy_reg;
    logic [15:0]        vu_reg, vv_reg;
    logic               vlast_reg;

    logic [15:0]   code_q;
    glyph_t        rec_q;
    glyph_t        wr_glyph;
    logic          wr_en;
    logic [AW-1:0] code_addr;

    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign wr_en = cmd.valid && cmd.ready && (cmd.op == OP_LOAD) && (count_reg < FULL);
    assign code_addr = scan_reg[AW-1:0];

    assign wr_glyph = '{off_x: cmd.offset_x, off_y: cmd.offset_y, w: cmd.glyph_w,
                        h: cmd.glyph_h, u: cmd.tex_u, v: cmd.tex_v, tw: cmd.tex_w,
                        th: cmd.tex_h, adv_x: cmd.advance_x, adv_y: cmd.advance_y};

    gqg_table #(.ENTRIES(GLYPH_ENTRIES), .AW(AW)) u_table (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (count_reg[AW-1:0]),
        .wr_code   (cmd.char_code),
        .wr_glyph  (wr_glyph),
        .code_addr (code_addr),
        .code_q    (code_q),
        .rec_addr  (hit_reg),
        .rec_q     (rec_q)
    );

    assign vtx.valid       = vvalid_reg;
    assign vtx.vert_x      = vx_reg;
    assign vtx.vert_y      = vy_reg;
    assign vtx.out_u       = vu_reg;
    assign vtx.out_v       = vv_reg;
    assign vtx.last_vertex = vlast_reg;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_x_reg <= SCALE_RESET;
            scale_y_reg <= SCALE_RESET;
            repl_reg    <= REPLACEMENT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SCALE_X:     scale_x_reg <= cfg.data;
                REG_SCALE_Y:     scale_y_reg <= cfg.data;
                REG_REPLACEMENT: repl_reg    <= cfg.data;
                default:         ;
            endcase
        end
    end

    // Command sequencer: scan, record read, scaling and vertex emission.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            pen_x_reg    <= '0;
            pen_y_reg    <= '0;
            vvalid_reg   <= 1'b0;
            scan_reg     <= '0;
            rd_valid_reg <= 1'b0;
            second_reg   <= 1'b0;
            vcnt_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        unique case (cmd.op)
                            OP_LOAD:
                            begin
                                if (count_reg < FULL)
                                    count_reg <= count_reg + 1'b1;
                                state_reg <= S_DONE;
                            end
                            OP_PLACE:
                            begin
                                code_reg     <= cmd.char_code;
                                key_reg      <= cmd.char_code;
                                second_reg   <= 1'b0;
                                scan_reg     <= '0;
                                rd_valid_reg <= 1'b0;
                                state_reg    <= (count_reg == '0) ? S_DONE : S_SCAN;
                            end
                            OP_PEN:
                            begin
                                pen_x_reg <= '0;
                                pen_y_reg <= '0;
                                state_reg <= S_DONE;
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_SCAN:
                begin
                    // Address issued this cycle; the code comes back next cycle.
                    rd_idx_reg   <= scan_reg;
                    rd_valid_reg <= 1'b1;
                    scan_reg     <= scan_reg + 1'b1;
                    state_reg    <= S_SCAN_CHECK;
                end
                S_SCAN_CHECK:
                begin
                    if (rd_valid_reg && code_q == key_reg)
                    begin
                        hit_reg   <= rd_idx_reg[AW-1:0];
                        state_reg <= S_REC_RD;
                    end
                    else if (scan_reg < count_reg)
                    begin
                        rd_idx_reg <= scan_reg;
                        scan_reg   <= scan_reg + 1'b1;
                    end
                    else if (!second_reg && code_reg != repl_reg)
                    begin
                        key_reg      <= repl_reg;
                        second_reg   <= 1'b1;
                        scan_reg     <= '0;
                        rd_valid_reg <= 1'b0;
                        state_reg    <= S_SCAN;
                    end
                    else
                    begin
                        hit_reg   <= '0;
                        state_reg <= S_REC_RD;
                    end
                end
                S_REC_RD:   state_reg <= S_REC_WAIT;
                S_REC_WAIT:
                begin
                    pa_reg <= 33'(rec_q.off_x * $signed({1'b0, scale_x_reg}));
                    pb_reg <= 33'(rec_q.off_y * $signed({1'b0, scale_y_reg}));
                    pc_reg <= 33'(rec_q.w * $signed({1'b0, scale_x_reg}));
                    pd_reg <= 33'(rec_q.h * $signed({1'b0, scale_y_reg}));
                    u0_reg <= rec_q.u;
                    v0_reg <= rec_q.v;
                    u1_reg <= satu16(rec_q.u, rec_q.tw);
                    v1_reg <= satu16(rec_q.v, rec_q.th);
                    state_reg <= S_MUL1;
                end
                S_MUL1:
                begin
                    sx_reg <= reduce_q(pa_reg);
                    sy_reg <= reduce_q(pb_reg);
                    sw_reg <= reduce_q(pc_reg);
                    sh_reg <= reduce_q(pd_reg);
                    pa_reg <= 33'(rec_q.adv_x * $signed({1'b0, scale_x_reg}));
                    pb_reg <= 33'(rec_q.adv_y * $signed({1'b0, scale_y_reg}));
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    ax_reg <= reduce_q(pa_reg);
                    ay_reg <= reduce_q(pb_reg);
                    x0_reg <= sat24(26'(sx_reg) + 26'(pen_x_reg));
                    y0_reg <= sat24(26'(sy_reg) + 26'(pen_y_reg));
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    x1_reg    <= sat24(26'(x0_reg) + 26'(sw_reg));
                    y1_reg    <= sat24(26'(y0_reg) + 26'(sh_reg));
                    pen_x_reg <= sat24(26'(pen_x_reg) + 26'(ax_reg));
                    pen_y_reg <= sat24(26'(pen_y_reg) + 26'(ay_reg));
                    vcnt_reg  <= '0;
                    state_reg <= (rec_q.w != 0 || rec_q.h != 0) ? S_EMIT : S_DONE;
                end
                S_EMIT:
                begin
                    if (!vvalid_reg || vtx.ready)
                    begin
                        vvalid_reg <= 1'b1;
                        vlast_reg  <= (vcnt_reg == 3'd5);
                        // Corner order v0,v2,v1,v0,v3,v2.
                        case (vcnt_reg)
                            3'd0, 3'd3:
                            begin
                                vx_reg <= x0_reg; vy_reg <= y0_reg;
                                vu_reg <= u0_reg; vv_reg <= v0_reg;
                            end
                            3'd2:
                            begin
                                vx_reg <= x1_reg; vy_reg <= y0_reg;
                                vu_reg <= u1_reg; vv_reg <= v0_reg;
                            end
                            3'd4:
                            begin
                                vx_reg <= x0_reg; vy_reg <= y1_reg;
                                vu_reg <= u0_reg; vv_reg <= v1_reg;
                            end
                            default:
                            begin
                                vx_reg <= x1_reg; vy_reg <= y1_reg;
                                vu_reg <= u1_reg; vv_reg <= v1_reg;
                            end
                        endcase
                        vcnt_reg <= vcnt_reg + 1'b1;
                        if (vcnt_reg == 3'd5)
                            state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!vvalid_reg || vtx.ready)
                    begin
                        vvalid_reg <= 1'b0;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (vvalid_reg && vtx.ready && state_reg != S_EMIT && state_reg != S_DONE)
                vvalid_reg <= 1'b0;
        end
    end

    // A stalled vertex word keeps its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vvalid_reg && !vtx.ready |=> vvalid_reg && $stable(vx_reg) && $stable(vlast_reg))
        else $error("vertex word changed under stall");

    // No command is taken while a vertex word is pending.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        vvalid_reg |-> !cmd.ready)
        else $error("command accepted with vertex pending");

    // The entry count never exceeds the table size.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("entry count overflow");

endmodule

[bench/tb_glyph_quad_generator_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_glyph_quad_generator_unit
// Self-checking bench for the glyph quad generator. Glyph records are loaded,
// characters are placed and the pen is reset, under changing scale and
// replacement settings. A predictor of the unit's own computes the vertex
// words of every accepted command word, and a scoreboard compares them, in
// order, with the words that leave the vertex channel.
// ----------------------------------------------------------------------------
module tb_glyph_quad_generator_unit;
    import gqg_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 300;

    // One vertex word as expected on the vertex channel.
    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic [15:0]        u;
        logic [15:0]        v;
        logic               last;
    } vertex_t;

    // One command word as offered on the command channel.
    typedef struct packed {
        logic [1:0]         op;
        logic [15:0]        code;
        logic signed [15:0] off_x;
        logic signed [15:0] off_y;
        logic signed [15:0] w;
        logic signed [15:0] h;
        logic [15:0]        u;
        logic [15:0]        v;
        logic [15:0]        tw;
        logic [15:0]        th;
        logic signed [15:0] adv_x;
        logic signed [15:0] adv_y;
    } command_t;

    // Text placement predictor and queue of pending vertex words.
    class quad_scoreboard;
        command_t           glyphs[GLYPH_ENTRIES_DEF];
        int                 glyph_count;
        logic signed [23:0] pen_x;
        logic signed [23:0] pen_y;
        logic [15:0]        scale_x;
        logic [15:0]        scale_y;
        logic [15:0]        replacement;
        vertex_t            pending[$];
        int                 failures;

        function new();
            glyph_count = 0;
            pen_x = 0;
            pen_y = 0;
            scale_x = SCALE_RESET;
            scale_y = SCALE_RESET;
            replacement = REPLACEMENT_RESET;
            failures = 0;
        endfunction

        function void write_register(reg_idx_t idx, logic [15:0] data);
            case (idx)
                REG_SCALE_X:     scale_x = data;
                REG_SCALE_Y:     scale_y = data;
                REG_REPLACEMENT: replacement = data;
                default:         ;
            endcase
        endfunction

        function logic signed [23:0] clamp24(longint a);
            if (a > 64'sd8388607)
                return 24'sd8388607;
            if (a < -64'sd8388608)
                return -24'sd8388608;
            return a[23:0];
        endfunction

        // Q8.8 times unsigned Q8.8, rounded half up to Q16.8.
        function logic signed [23:0] scaled(logic signed [15:0] a, logic [15:0] s);
            longint p;
            p = longint'(a) * longint'({1'b0, s});
            return clamp24((p + 128) >>> 8);
        endfunction

        function logic [15:0] tex_add(logic [15:0] a, logic [15:0] b);
            int s;
            s = int'(a) + int'(b);
            return s > 65535 ? 16'hFFFF : s[15:0];
        endfunction

        function int lookup(logic [15:0] code);
            for (int i = 0; i < glyph_count; i++)
                if (glyphs[i].code == code)
                    return i;
            return -1;
        endfunction

        // Note an accepted command word and queue the vertex words it causes.
        function void note_command(command_t c);
            int                 idx;
            logic signed [23:0] x0, y0, x1, y1;
            logic [15:0]        u0, v0, u1, v1;
            if (c.op == OP_LOAD)
            begin
                if (glyph_count < GLYPH_ENTRIES_DEF)
                begin
                    glyphs[glyph_count] = c;
                    glyph_count++;
                end
            end
            else if (c.op == OP_PEN)
            begin
                pen_x = 0;
                pen_y = 0;
            end
            else if (c.op == OP_PLACE && glyph_count > 0)
            begin
                idx = lookup(c.code);
                if (idx < 0 && c.code != replacement)
                    idx = lookup(replacement);
                if (idx < 0)
                    idx = 0;
                if (glyphs[idx].w != 0 || glyphs[idx].h != 0)
                begin
                    x0 = clamp24(longint'(scaled(glyphs[idx].off_x, scale_x)) + pen_x);
                    y0 = clamp24(longint'(scaled(glyphs[idx].off_y, scale_y)) + pen_y);
                    x1 = clamp24(longint'(x0) + scaled(glyphs[idx].w, scale_x));
                    y1 = clamp24(longint'(y0) + scaled(glyphs[idx].h, scale_y));
                    u0 = glyphs[idx].u;
                    v0 = glyphs[idx].v;
                    u1 = tex_add(u0, glyphs[idx].tw);
                    v1 = tex_add(v0, glyphs[idx].th);
                    pending.push_back('{x0, y0, u0, v0, 1'b0});
                    pending.push_back('{x1, y1, u1, v1, 1'b0});
                    pending.push_back('{x1, y0, u1, v0, 1'b0});
                    pending.push_back('{x0, y0, u0, v0, 1'b0});
                    pending.push_back('{x0, y1, u0, v1, 1'b0});
                    pending.push_back('{x1, y1, u1, v1, 1'b1});
                end
                pen_x = clamp24(longint'(pen_x) + scaled(glyphs[idx].adv_x, scale_x));
                pen_y = clamp24(longint'(pen_y) + scaled(glyphs[idx].adv_y, scale_y));
            end
        endfunction

        // Compare an accepted vertex word with the oldest expectation.
        function void check_vertex(vertex_t got);
            vertex_t exp_v;
            if (pending.size() == 0)
            begin
                $error("unexpected vertex word x=%0d y=%0d", got.x, got.y);
                failures++;
                return;
            end
            exp_v = pending.pop_front();
            if (got.x !== exp_v.x)
            begin
                $error("vert_x: expected %0d, got %0d", exp_v.x, got.x);
                failures++;
            end
            if (got.y !== exp_v.y)
            begin
                $error("vert_y: expected %0d, got %0d", exp_v.y, got.y);
                failures++;
            end
            if (got.u !== exp_v.u)
            begin
                $error("out_u: expected %0d, got %0d", exp_v.u, got.u);
                failures++;
            end
            if (got.v !== exp_v.v)
            begin
                $error("out_v: expected %0d, got %0d", exp_v.v, got.v);
                failures++;
            end
            if (got.last !== exp_v.last)
            begin
                $error("last_vertex: expected %0d, got %0d", exp_v.last, got.last);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    gqg_cmd_if cmd ();
    gqg_vtx_if vtx ();
    gqg_cfg_if cfg ();

    quad_scoreboard board;

    int  idle_pct;
    int  hold_off;
    int  quiet_cycles;
    bit  timed_out;

    glyph_quad_generator_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .vtx   (vtx.source),
        .cfg   (cfg.sink)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Accepted words on every channel: predict, check and feed the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd.valid && cmd.ready)
                board.note_command('{cmd.op, cmd.char_code, cmd.offset_x, cmd.offset_y,
                                     cmd.glyph_w, cmd.glyph_h, cmd.tex_u, cmd.tex_v,
                                     cmd.tex_w, cmd.tex_h, cmd.advance_x, cmd.advance_y});
            if (vtx.valid && vtx.ready)
                board.check_vertex('{vtx.vert_x, vtx.vert_y, vtx.out_u, vtx.out_v,
                                     vtx.last_vertex});
            if ((cmd.valid && cmd.ready) || (vtx.valid && vtx.ready) ||
                (cfg.valid && cfg.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: random stalls, and a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (!rst_n)
            vtx.ready <= 1'b0;
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            vtx.ready <= 1'b0;
        end
        else
            vtx.ready <= ($urandom_range(99) >= idle_pct);
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offer one command word, with a random idle gap before it.
    task automatic send_command(command_t c);
        while ($urandom_range(99) < idle_pct)
            @(posedge clk);
        cmd.valid     <= 1'b1;
        cmd.op        <= c.op;
        cmd.char_code <= c.code;
        cmd.offset_x  <= c.off_x;
        cmd.offset_y  <= c.off_y;
        cmd.glyph_w   <= c.w;
        cmd.glyph_h   <= c.h;
        cmd.tex_u     <= c.u;
        cmd.tex_v     <= c.v;
        cmd.tex_w     <= c.tw;
        cmd.tex_h     <= c.th;
        cmd.advance_x <= c.adv_x;
        cmd.advance_y <= c.adv_y;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        // The unit is busy for the next cycle anyway, so this gap costs nothing.
        cmd.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Write one register; only called while the unit is idle.
    task automatic write_register(reg_idx_t idx, logic [15:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        board.write_register(idx, data);
        @(posedge clk);
    endtask

    // Wait until every expected vertex word has come, then let the unit settle.
    task automatic drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic command_t glyph_load(logic [15:0] code);
        command_t c;
        c.op    = OP_LOAD;
        c.code  = code;
        c.off_x = $urandom_range(2047) - 1024;
        c.off_y = $urandom_range(2047) - 1024;
        c.w     = $urandom_range(4095);
        c.h     = $urandom_range(4095);
        c.u     = $urandom;
        c.v     = $urandom;
        c.tw    = $urandom_range(4095);
        c.th    = $urandom_range(4095);
        c.adv_x = $urandom_range(4095);
        c.adv_y = $urandom_range(511) - 256;
        return c;
    endfunction

    function automatic command_t random_command(bit wild);
        command_t c;
        c = wild ? command_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom})
                 : glyph_load($urandom_range(15) + 60);
        return c;
    endfunction

    function automatic command_t place(logic [15:0] code);
        command_t c;
        c = command_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        c.op   = OP_PLACE;
        c.code = code;
        return c;
    endfunction

    function automatic command_t with_op(op_t op);
        command_t c;
        c = command_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        c.op = op;
        return c;
    endfunction

    // Stimulus.
    initial
    begin
        command_t c;
        int       r;
        board = new();
        board.scale_y = SCALE_RESET;
        idle_pct = 31;
        hold_off = 0;
        quiet_cycles = 0;
        timed_out = 1'b0;
        rst_n = 1'b0;
        cmd.valid = 1'b0;
        cmd.op = OP_NONE;
        cmd.char_code = '0;
        cmd.offset_x = '0;
        cmd.offset_y = '0;
        cmd.glyph_w = '0;
        cmd.glyph_h = '0;
        cmd.tex_u = '0;
        cmd.tex_v = '0;
        cmd.tex_w = '0;
        cmd.tex_h = '0;
        cmd.advance_x = '0;
        cmd.advance_y = '0;
        cfg.valid = 1'b0;
        cfg.index = REG_SCALE_X;
        cfg.data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty table, extremes, fall-backs and special ops.
        send_command(place(16'd65));
        send_command(with_op(OP_NONE));
        c = '{OP_LOAD, 16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF,
              16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 16'sh8000};
        send_command(c);
        c = '{OP_LOAD, 16'd0, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000,
              16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 16'sh8000, 16'sh7FFF};
        send_command(c);
        c = glyph_load(16'd32);
        c.w = 0;
        c.h = 0;
        send_command(c);
        send_command(glyph_load(16'd63));
        send_command(glyph_load(16'd65));
        send_command(glyph_load(16'd65));
        send_command(place(16'hFFFF));
        send_command(place(16'd0));
        send_command(place(16'd32));
        send_command(place(16'd65));
        send_command(place(16'd1000));
        send_command(with_op(OP_PEN));
        for (int i = 0; i < 4; i++)
            send_command(place(16'hFFFF));
        send_command(with_op(OP_PEN));
        drain();
        write_register(REG_REPLACEMENT, 16'd5000);
        write_register(REG_SCALE_X, 16'hFFFF);
        write_register(REG_SCALE_Y, 16'h0000);
        send_command(place(16'd1000));
        send_command(place(16'd0));
        send_command(place(16'd5000));
        drain();

        // Long receiver hold-off while commands keep coming.
        write_register(REG_SCALE_X, 16'd256);
        write_register(REG_SCALE_Y, 16'd384);
        hold_off = 400;
        for (int i = 0; i < 8; i++)
            send_command(place(16'd65));
        drain();

        // Random phases under different settings; one phase without idling.
        for (int phase = 0; phase < 5; phase++)
        begin
            write_register(REG_SCALE_X, phase == 4 ? 16'd0 : 16'($urandom_range(1023)));
            write_register(REG_SCALE_Y, phase == 3 ? 16'hFFFF : 16'($urandom_range(1023)));
            write_register(REG_REPLACEMENT, 16'($urandom_range(63) + 40));
            idle_pct = (phase == 2) ? 0 : 31;
            for (int i = 0; i < 26; i++)
            begin
                r = $urandom_range(99);
                if (r < 25)
                    c = random_command(r < 3);
                else if (r < 85)
                    c = place(16'($urandom_range(20) + 58));
                else if (r < 92)
                    c = with_op(OP_PEN);
                else if (r < 95)
                    c = with_op(OP_NONE);
                else
                    c = place($urandom);
                send_command(c);
            end
            drain();
        end

        // Fill the table past its end; further loads are dropped.
        while (board.glyph_count < GLYPH_ENTRIES_DEF)
            send_command(glyph_load($urandom));
        send_command(glyph_load(16'd7));
        for (int i = 0; i < 10; i++)
            send_command(place(i == 0 ? 16'd7 : $urandom));
        drain();

        if (board.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
